// ----- sv/rti_pkg.sv -----
`timescale 1ns / 1ps

package rti_pkg;

  // Table geometry and number format
  localparam int TABLE_ENTRIES = 105;
  localparam int LOWEST_DEGREE = -42;
  localparam int FRACTION_BITS = 8;

  localparam int RES_W  = 16;
  localparam int TEMP_W = 15;
  localparam int IDX_W  = $clog2(TABLE_ENTRIES);
  localparam int QUO_W  = FRACTION_BITS + 1;
  // One quotient bit per divide step
  localparam int DIV_STEPS = FRACTION_BITS + 1;
  localparam int DIVC_W    = $clog2(DIV_STEPS);

  // PT100 resistance in centiohms, one entry per whole degree from LOWEST_DEGREE
  localparam logic [RES_W-1:0] RTD_ROM [TABLE_ENTRIES] = '{
    16'd8348,  16'd8388,
    16'd8427,  16'd8467,  16'd8506,  16'd8546,  16'd8585,  16'd8625,  16'd8664,
    16'd8704,  16'd8743,  16'd8783,
    16'd8822,  16'd8862,  16'd8901,  16'd8940,  16'd8980,  16'd9019,  16'd9059,
    16'd9098,  16'd9137,  16'd9177,
    16'd9216,  16'd9255,  16'd9295,  16'd9334,  16'd9373,  16'd9412,  16'd9452,
    16'd9491,  16'd9530,  16'd9569,
    16'd9609,  16'd9648,  16'd9687,  16'd9726,  16'd9765,  16'd9804,  16'd9844,
    16'd9883,  16'd9922,  16'd9961,
    16'd10000, 16'd10039, 16'd10078, 16'd10117, 16'd10156, 16'd10195, 16'd10234,
    16'd10273, 16'd10312, 16'd10351,
    16'd10390, 16'd10429, 16'd10468, 16'd10507, 16'd10546, 16'd10585, 16'd10624,
    16'd10663, 16'd10702, 16'd10740,
    16'd10779, 16'd10818, 16'd10857, 16'd10896, 16'd10935, 16'd10973, 16'd11012,
    16'd11051, 16'd11090, 16'd11129,
    16'd11167, 16'd11206, 16'd11245, 16'd11283, 16'd11322, 16'd11361, 16'd11400,
    16'd11438, 16'd11477, 16'd11515,
    16'd11554, 16'd11593, 16'd11631, 16'd11670, 16'd11708, 16'd11747, 16'd11786,
    16'd11824, 16'd11863, 16'd11901,
    16'd11940, 16'd11978, 16'd12017, 16'd12055, 16'd12094, 16'd12132, 16'd12171,
    16'd12209, 16'd12247, 16'd12286,
    16'd12324, 16'd12363, 16'd12401
  };

  // Table lookup; indexes past the end read as zero
  function automatic logic [RES_W-1:0] rom_read(input logic [IDX_W-1:0] idx);
    if (int'(idx) < TABLE_ENTRIES) begin
      rom_read = RTD_ROM[idx];
    end else begin
      rom_read = '0;
    end
  endfunction

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;
    logic search_step;
    logic setup;
    logic div_step;
    logic load_out;
  } rti_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_of_range;
    logic search_done;
  } rti_sts_t;

endpackage

// ----- sv/rti_dp.sv -----
`timescale 1ns / 1ps

module rti_dp (
  input  logic                         clk_i,
  input  rti_pkg::rti_cmd_t            cmd_i,
  output rti_pkg::rti_sts_t            sts_o,
  input  logic [rti_pkg::RES_W-1:0]    resistance_centiohm_i,
  output logic signed [rti_pkg::TEMP_W-1:0] temperature_q8_o,
  output logic                         out_of_range_o
);
  import rti_pkg::*;

  logic [RES_W-1:0]  r_q;
  logic              oor_q;
  logic [IDX_W-1:0]  lo_q, hi_q;
  logic [IDX_W-1:0]  seg_q;
  logic [RES_W:0]    x_q;
  logic [RES_W-1:0]  span_q;
  logic [QUO_W-1:0]  quo_q;
  logic signed [TEMP_W-1:0] temp_q;
  logic              oor_out_q;

  logic [IDX_W:0]    mid_sum;
  logic [IDX_W-1:0]  mid;
  logic [RES_W-1:0]  mid_val;
  logic [IDX_W-1:0]  seg_sel;
  logic [RES_W-1:0]  seg_a, seg_b;
  logic              in_oor;
  logic              div_ge;
  logic [RES_W:0]    x_rem;
  logic [31:0]       deg_full, temp_full;

  // Range check against the table ends
  assign in_oor = (resistance_centiohm_i < RTD_ROM[0]) ||
                  (resistance_centiohm_i > RTD_ROM[TABLE_ENTRIES-1]);

  // Binary search probe: lowest index whose entry is >= r
  assign mid_sum = (IDX_W+1)'(lo_q) + (IDX_W+1)'(hi_q);
  assign mid     = mid_sum[IDX_W:1];
  assign mid_val = rom_read(mid);

  // Segment below the found entry, segment 0 when r sits on the first entry
  assign seg_sel = (lo_q == '0) ? '0 : lo_q - IDX_W'(1);
  assign seg_a   = rom_read(seg_sel);
  assign seg_b   = rom_read(seg_sel + IDX_W'(1));

  // Restoring divide step; zero span yields a zero fraction
  assign div_ge = (span_q != '0) && (x_q >= {1'b0, span_q});
  assign x_rem  = div_ge ? (x_q - {1'b0, span_q}) : x_q;

  // Whole degrees shifted into place plus the fraction, wrapped to the port
  assign deg_full  = 32'(LOWEST_DEGREE) + 32'(seg_q);
  assign temp_full = (deg_full << FRACTION_BITS) + 32'(quo_q);

  // Input capture and search bounds
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      r_q   <= resistance_centiohm_i;
      oor_q <= in_oor;
      lo_q  <= '0;
      hi_q  <= IDX_W'(TABLE_ENTRIES - 1);
    end else if (cmd_i.search_step) begin
      if (mid_val >= r_q) begin
        hi_q <= mid;
      end else begin
        lo_q <= mid + IDX_W'(1);
      end
    end
  end

  // Segment setup and serial divide
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      seg_q  <= seg_sel;
      x_q    <= {1'b0, r_q - seg_a};
      span_q <= seg_b - seg_a;
      quo_q  <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[QUO_W-2:0], div_ge};
      x_q   <= {x_rem[RES_W-1:0], 1'b0};
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      temp_q    <= oor_q ? '0 : signed'(temp_full[TEMP_W-1:0]);
      oor_out_q <= oor_q;
    end
  end

  assign sts_o.out_of_range = oor_q;
  assign sts_o.search_done  = (lo_q == hi_q);
  assign temperature_q8_o   = temp_q;
  assign out_of_range_o     = oor_out_q;

endmodule

// ----- sv/rti_ctrl.sv -----
`timescale 1ns / 1ps

module rti_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output rti_pkg::rti_cmd_t cmd_o,
  input  rti_pkg::rti_sts_t sts_i
);
  import rti_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SEARCH = 5'b00010,
    S_SETUP  = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_RESULT = 5'b10000
  } rti_state_e;

  rti_state_e        state_q, state_d;
  logic [DIVC_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              in_xact;
  logic              slot_free;

  assign in_xact   = in_valid_i && !in_stall_o;
  assign slot_free = !out_valid_q || !out_stall_i;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (sts_i.out_of_range) begin
          state_d = S_RESULT;
        end else if (sts_i.search_done) begin
          state_d = S_SETUP;
        end else begin
          cmd_o.search_step = 1'b1;
        end
      end
      S_SETUP: begin
        cmd_o.setup = 1'b1;
        cnt_d       = '0;
        state_d     = S_DIVIDE;
      end
      S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == DIVC_W'(DIV_STEPS - 1)) begin
          state_d = S_RESULT;
        end else begin
          cnt_d = cnt_q + DIVC_W'(1);
        end
      end
      S_RESULT: begin
        if (slot_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // A new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> slot_free)
    else $error("result loaded over a pending transaction");

  // An accepted transaction always enters the search
  a_accept_to_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact |=> (state_q == S_SEARCH))
    else $error("accepted transaction did not start the search");

  // Divide counter stays within the quotient length
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIVIDE) |-> (cnt_q <= DIVC_W'(DIV_STEPS - 1)))
    else $error("divide counter overran");

  // Divide is entered only through setup
  a_div_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == S_DIVIDE) |-> ($past(state_q) == S_SETUP))
    else $error("divide entered without setup");
`endif

endmodule

// ----- sv/rtd_table_interpolator_core.sv -----
`timescale 1ns / 1ps

// PT100 table interpolator: takes a resistance in centiohms, locates its
// segment in a 105-entry table (-42 C to 62 C, one entry per degree) by binary
// search and interpolates linearly, returning degrees C with 8 fraction bits.
// Readings outside the table raise out_of_range with a zero temperature.
// One transaction at a time: accept, binary search, segment setup, serial
// restoring divide and a load into the output register; an out-of-range
// reading goes from the search straight to the output register. The output
// register lets the next transaction be accepted while a result still
// waits to be taken.
module rtd_table_interpolator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rti_pkg::RES_W-1:0]         resistance_centiohm_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rti_pkg::TEMP_W-1:0] temperature_q8_o,
  output logic                              out_of_range_o
);
  import rti_pkg::*;

  rti_cmd_t cmd;
  rti_sts_t sts;

  // Sequencer
  rti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Search, divide and output register
  rti_dp u_dp (
    .clk_i                 (clk_i),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .resistance_centiohm_i (resistance_centiohm_i),
    .temperature_q8_o      (temperature_q8_o),
    .out_of_range_o        (out_of_range_o)
  );

endmodule

// ----- tb/sv/rtd_table_interpolator_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the interpolator, predicts each temperature from
// its own copy of the PT100 table and compares results in order.
module rtd_table_interpolator_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [rti_pkg::RES_W-1:0]         resistance_centiohm_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic signed [rti_pkg::TEMP_W-1:0] temperature_q8_i,
  input  logic                              out_of_range_i,
  output int                                mismatches_o,
  output int                                outstanding_o
);

  localparam int N_POINTS   = 105;
  localparam int FIRST_DEG  = -42;
  localparam int Q_BITS     = 8;
  localparam int TW         = rti_pkg::TEMP_W;
  localparam int PRINT_CAP  = 50;

  // Centiohms per whole degree, -42 C upward
  localparam int PT100_CENTIOHM [N_POINTS] = '{
    8348, 8388,
    8427, 8467, 8506, 8546, 8585, 8625, 8664, 8704, 8743, 8783,
    8822, 8862, 8901, 8940, 8980, 9019, 9059, 9098, 9137, 9177,
    9216, 9255, 9295, 9334, 9373, 9412, 9452, 9491, 9530, 9569,
    9609, 9648, 9687, 9726, 9765, 9804, 9844, 9883, 9922, 9961,
    10000, 10039, 10078, 10117, 10156, 10195, 10234, 10273, 10312, 10351,
    10390, 10429, 10468, 10507, 10546, 10585, 10624, 10663, 10702, 10740,
    10779, 10818, 10857, 10896, 10935, 10973, 11012, 11051, 11090, 11129,
    11167, 11206, 11245, 11283, 11322, 11361, 11400, 11438, 11477, 11515,
    11554, 11593, 11631, 11670, 11708, 11747, 11786, 11824, 11863, 11901,
    11940, 11978, 12017, 12055, 12094, 12132, 12171, 12209, 12247, 12286,
    12324, 12363, 12401
  };

  typedef struct packed {
    logic [rti_pkg::RES_W-1:0] reading;
    logic signed [TW-1:0]      temperature;
    logic                      out_of_range;
  } temp_reading_t;

  temp_reading_t expected_temps [$];
  int            mismatch_count;

  assign mismatches_o = mismatch_count;

  // Lowest segment holding r, linear fraction truncated
  function automatic temp_reading_t predict_temperature(input logic [rti_pkg::RES_W-1:0] r);
    temp_reading_t res;
    int            r_int;
    int            lo_r;
    int            hi_r;
    int            frac;
    r_int            = int'(r);
    res.reading      = r;
    res.temperature  = '0;
    res.out_of_range = 1'b1;
    if (r_int >= PT100_CENTIOHM[0] && r_int <= PT100_CENTIOHM[N_POINTS-1]) begin
      // scan downward so the lowest matching segment wins
      for (int seg = N_POINTS - 2; seg >= 0; seg--) begin
        lo_r = PT100_CENTIOHM[seg];
        hi_r = PT100_CENTIOHM[seg+1];
        if (r_int >= lo_r && r_int <= hi_r) begin
          frac = (hi_r != lo_r) ? ((r_int - lo_r) << Q_BITS) / (hi_r - lo_r) : 0;
          res.temperature  = TW'((FIRST_DEG + seg) * (1 << Q_BITS) + frac);
          res.out_of_range = 1'b0;
        end
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want,
                                 input int reading);
    if (mismatch_count < PRINT_CAP) begin
      $display("%0t ns: %s mismatch for reading %0d: got %0d, expected %0d",
               $time, what, reading, got, want);
    end
    mismatch_count++;
  endtask

  // Compare the oldest expectation first, then record the new transaction
  always @(posedge clk_i or negedge rst_ni) begin
    temp_reading_t want;
    if (!rst_ni) begin
      expected_temps.delete();
      mismatch_count = 0;
      outstanding_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_temps.size() == 0) begin
          report_mismatch("unexpected result", int'(temperature_q8_i), 0, -1);
        end else begin
          want = expected_temps.pop_front();
          if (temperature_q8_i !== want.temperature) begin
            report_mismatch("temperature_q8", int'(temperature_q8_i),
                            int'(want.temperature), int'(want.reading));
          end
          if (out_of_range_i !== want.out_of_range) begin
            report_mismatch("out_of_range", int'(out_of_range_i),
                            int'(want.out_of_range), int'(want.reading));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_temps.push_back(predict_temperature(resistance_centiohm_i));
      end
      outstanding_o <= expected_temps.size();
    end
  end

endmodule

// ----- tb/sv/rtd_table_interpolator_core_tb.sv -----
`timescale 1ns / 1ps

module rtd_table_interpolator_core_tb;

  localparam int RANDOM_READINGS = 950;
  localparam int IDLE_PERCENT    = 12;
  localparam int STALL_LIMIT     = 2000;
  localparam int TAIL_CYCLES     = 60;
  // no idling on either side for these random readings
  localparam int QUIET_FIRST     = 400;
  localparam int QUIET_LAST      = 549;
  localparam int DRAIN_AT        = 700;

  localparam int TABLE_LO = 8348;
  localparam int TABLE_HI = 12401;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [rti_pkg::RES_W-1:0]         resistance_centiohm_i;
  logic                              out_valid_o;
  logic                              out_stall_i = 1'b0;
  logic signed [rti_pkg::TEMP_W-1:0] temperature_q8_o;
  logic                              out_of_range_o;

  logic quiet_phase = 1'b0;
  int   mismatches;
  int   outstanding;
  int   idle_cycles;

  rtd_table_interpolator_core dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .resistance_centiohm_i (resistance_centiohm_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .temperature_q8_o      (temperature_q8_o),
    .out_of_range_o        (out_of_range_o)
  );

  rtd_table_interpolator_checker u_checker (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_i            (in_stall_o),
    .resistance_centiohm_i (resistance_centiohm_i),
    .out_valid_i           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .temperature_q8_i      (temperature_q8_o),
    .out_of_range_i        (out_of_range_o),
    .mismatches_o          (mismatches),
    .outstanding_o         (outstanding)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Result side back-pressure
  always @(posedge clk_i) begin
    out_stall_i <= !quiet_phase && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Watchdog: cycles without any transaction on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // One reading, with an occasional gap ahead of it
  task automatic send_reading(input logic [rti_pkg::RES_W-1:0] r);
    if (!quiet_phase && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i            <= 1'b1;
    resistance_centiohm_i <= r;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Hold off until every result in flight has been taken
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  function automatic logic [rti_pkg::RES_W-1:0] pick_reading();
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) begin
      return rti_pkg::RES_W'($urandom_range(TABLE_HI, TABLE_LO));
    end else if (sel < 85) begin
      // hug the table ends
      if ($urandom_range(1)) begin
        return rti_pkg::RES_W'(TABLE_LO - 3 + $urandom_range(6));
      end
      return rti_pkg::RES_W'(TABLE_HI - 3 + $urandom_range(6));
    end
    return rti_pkg::RES_W'($urandom);
  endfunction

  initial begin
    logic [rti_pkg::RES_W-1:0] directed [$];
    rst_ni                = 1'b0;
    in_valid_i            = 1'b0;
    resistance_centiohm_i = '0;
    idle_cycles           = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, table ends, inner entries, mid-segment
    directed = '{16'd0, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000,
                 16'd8347, 16'd8348, 16'd8349, 16'd8368, 16'd8387, 16'd8388,
                 16'd8389, 16'd9999, 16'd10000, 16'd10001, 16'd10740,
                 16'd12363, 16'd12400, 16'd12401, 16'd12402, 16'd1, 16'd65534};
    foreach (directed[i]) send_reading(directed[i]);
    drain_results();

    // Random readings, with one quiet stretch and one full drain
    for (int n = 0; n < RANDOM_READINGS; n++) begin
      quiet_phase <= (n >= QUIET_FIRST && n <= QUIET_LAST);
      if (n == DRAIN_AT) drain_results();
      send_reading(pick_reading());
    end
    in_valid_i  <= 1'b0;
    quiet_phase <= 1'b0;

    // count of results in flight is registered, so it trails the last transaction
    do @(posedge clk_i); while (outstanding != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
